/* rtl/ogh_pkg.sv */
// Shared types and constants for the ordered generational handle table.
// Used by the channel interfaces, the front end, the back end and the top level.
package ogh_pkg;

   localparam int HANDLE_W = 32;
   localparam int SERIAL_W = 16;
   localparam int RANK_W   = 16;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC       = 3'd0,
      OP_INSERT      = 3'd1,
      OP_REMOVE      = 3'd2,
      OP_MOVE_BEFORE = 3'd3,
      OP_MOVE_TAIL   = 3'd4,
      OP_LOOKUP      = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_DONE      = 2'd0,
      STS_INVALID   = 2'd1,
      STS_FULL      = 2'd2,
      STS_NO_CHANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic                used;
      logic [SERIAL_W-1:0] serial;
      logic [RANK_W-1:0]   rank;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Classified transaction handed from the front end to the back end.
   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [HANDLE_W-1:0] handle_a;
      logic [HANDLE_W-1:0] handle_b;
      logic                a_ok;
      logic                b_ok;
      logic                same;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle_out;
      logic [RANK_W-1:0]   rank_out;
   } result_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_CHK_A,
      BK_CHK_B,
      BK_FIND,
      BK_RENUM,
      BK_COMMIT,
      BK_COMMIT_B,
      BK_RESP
   } back_state_type;

endpackage

/* rtl/ogh_if.sv */
// Valid/ready channel interfaces for request and response transactions.
// Depends on ogh_pkg for field widths.
interface ogh_req_if;
   import ogh_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [HANDLE_W-1:0] handle_a;
   logic [HANDLE_W-1:0] handle_b;
   modport source (output valid, output operation, output handle_a, output handle_b,
                   input ready);
   modport sink   (input valid, input operation, input handle_a, input handle_b,
                   output ready);
endinterface

interface ogh_rsp_if;
   import ogh_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] handle_out;
   logic [RANK_W-1:0]   rank_out;
   modport source (output valid, output status, output handle_out, output rank_out,
                   input ready);
   modport sink   (input valid, input status, input handle_out, input rank_out,
                   output ready);
endinterface

/* rtl/ordered_generational_handle_table.sv */
// Ordered generational handle table: a front end queues up to two request
// transactions while the back end works through one at a time against a
// slot RAM with one write port and one registered read port, reading one slot
// per cycle. After reset the back end clears every slot of the RAM before it
// takes a transaction. In the back end an invalid handle caught on the index or
// an unknown operation goes straight to the response, and lookup reads the slot
// of its handle; allocate makes one pass over the table, remove and move to tail
// make one pass, and move before at most one; insert makes two (one to find a
// free slot and the highest rank, one to renumber). A result then waits in the
// output register until taken, and the back end stalls only while that register
// is still full.
// Depends on ogh_pkg, ogh_if, ogh_ram, ogh_front and ogh_back.
module ordered_generational_handle_table #(
   parameter int SLOT_COUNT = 256
) (
   input  logic      clock,
   input  logic      reset,
   ogh_req_if.sink   req_chan,
   ogh_rsp_if.source rsp_chan
);
   import ogh_pkg::*;

   localparam int IW = $clog2(SLOT_COUNT);

   logic               q_valid, q_pop;
   cmd_type            q_item;
   logic               wr_en;
   logic [IW-1:0]      wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;

   ogh_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   ogh_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .rsp_chan (rsp_chan)
   );

   ogh_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_COUNT)) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );
endmodule

/* rtl/ogh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ogh_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/ogh_front.sv */
// Front end: accepts request transactions, classifies handles, queues them.
// Depends on ogh_pkg and ogh_if.
module ogh_front #(
   parameter int SLOT_COUNT = 256
) (
   input  logic             clock,
   input  logic             reset,
   ogh_req_if.sink          req_chan,
   output logic             q_valid,
   output ogh_pkg::cmd_type q_item,
   input  logic             q_pop
);
   import ogh_pkg::*;

   cmd_type    q_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic       push;
   cmd_type    cls;

   function automatic logic idx_ok(input logic [HANDLE_W-1:0] h);
      logic [31:0] idx;
      idx = {16'd0, h[15:0]};
      return (idx != 32'd0) && (idx < 32'(SLOT_COUNT));
   endfunction

   always_comb begin
      cls.op       = req_chan.operation;
      cls.handle_a = req_chan.handle_a;
      cls.handle_b = req_chan.handle_b;
      cls.a_ok     = idx_ok(req_chan.handle_a);
      cls.b_ok     = idx_ok(req_chan.handle_b);
      cls.same     = (req_chan.handle_a == req_chan.handle_b);
   end

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign q_valid        = (count_ff != 2'd0);
   assign q_item         = q_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end
endmodule

/* rtl/ogh_back.sv */
// Back end: sequencer that checks handles, scans the slot RAM and commits updates.
// Depends on ogh_pkg and ogh_if; drives the slot RAM held in the top level.
module ogh_back #(
   parameter int SLOT_COUNT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  ogh_pkg::cmd_type                  q_item,
   output logic                              q_pop,
   output logic                              wr_en,
   output logic [$clog2(SLOT_COUNT)-1:0]     wr_addr,
   output logic [ogh_pkg::ENTRY_W-1:0]       wr_data,
   output logic [$clog2(SLOT_COUNT)-1:0]     rd_addr,
   input  logic [ogh_pkg::ENTRY_W-1:0]       rd_data,
   ogh_rsp_if.source                         rsp_chan
);
   import ogh_pkg::*;

   localparam int IW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(SLOT_COUNT + 1);

   back_state_type      state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [RANK_W-1:0]   rank_a_ff, rank_a_in, rank_b_ff, rank_b_in;
   logic [CW-1:0]       addr_ff, addr_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [IW-1:0]       rd_addr_ff, rd_addr_in;
   logic                free_found_ff, free_found_in;
   logic [IW-1:0]       free_idx_ff, free_idx_in;
   logic [RANK_W-1:0]   max_ff, max_in;
   logic                tail_found_ff, tail_found_in;
   logic [SERIAL_W-1:0] serial_ff, serial_in;
   result_type          res_ff, res_in;
   logic                rsp_vld_ff, rsp_vld_in;
   result_type          rsp_ff, rsp_in;

   entry_type           ent;
   logic                issue, scan_done, ent_match_a, ent_match_b, hit;
   logic [RANK_W-1:0]   new_rank, rank_lo_b;
   logic [SERIAL_W-1:0] new_ser, ser_a, ser_b;
   logic [IW-1:0]       idx_a, idx_b;

   assign ent       = entry_type'(rd_data);
   assign issue     = (addr_ff < CW'(SLOT_COUNT));
   assign scan_done = !issue && !rd_vld_ff;
   assign idx_a     = cmd_ff.handle_a[IW-1:0];
   assign idx_b     = cmd_ff.handle_b[IW-1:0];
   assign ser_a     = cmd_ff.handle_a[31:16];
   assign ser_b     = cmd_ff.handle_b[31:16];
   assign new_ser   = ((serial_ff + 16'd1) == 16'd0) ? 16'd1 : serial_ff + 16'd1;
   assign ent_match_a = ent.used && (ent.serial == ser_a);
   assign ent_match_b = ent.used && (ent.serial == ser_b);
   assign rank_lo_b   = rank_b_ff - 16'd1;

   assign rsp_chan.valid      = rsp_vld_ff;
   assign rsp_chan.status     = rsp_ff.status;
   assign rsp_chan.handle_out = rsp_ff.handle_out;
   assign rsp_chan.rank_out   = rsp_ff.rank_out;

   // Rank update applied to one used entry during the renumbering pass.
   always_comb begin
      hit      = 1'b0;
      new_rank = ent.rank;
      unique case (cmd_ff.op)
         OP_INSERT: begin
            hit      = (ent.rank >= rank_a_ff);
            new_rank = ent.rank + 16'd1;
         end
         OP_REMOVE, OP_MOVE_TAIL: begin
            hit      = (ent.rank > rank_a_ff);
            new_rank = ent.rank - 16'd1;
         end
         OP_MOVE_BEFORE: begin
            if (rank_a_ff < rank_b_ff) begin
               hit      = (ent.rank >= rank_a_ff) && (ent.rank < rank_b_ff);
               new_rank = ent.rank - 16'd1;
            end else begin
               hit      = (ent.rank > rank_b_ff) && (ent.rank < rank_a_ff);
               new_rank = ent.rank + 16'd1;
            end
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      rank_a_in     = rank_a_ff;
      rank_b_in     = rank_b_ff;
      addr_in       = addr_ff;
      rd_vld_in     = 1'b0;
      rd_addr_in    = rd_addr_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      max_in        = max_ff;
      tail_found_in = tail_found_ff;
      serial_in     = serial_ff;
      res_in        = res_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_chan.ready;
      rsp_in        = rsp_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = rd_addr_ff;
      wr_data       = rd_data;
      rd_addr       = addr_ff[IW-1:0];

      unique case (state_ff)
         BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff[IW-1:0];
            wr_data = '0;
            addr_in = addr_ff + CW'(1);
            if (addr_ff == CW'(SLOT_COUNT - 1)) begin
               state_in = BK_IDLE;
            end
         end

         BK_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               cmd_in  = q_item;
               rd_addr = q_item.handle_a[IW-1:0];
               unique case (q_item.op)
                  OP_ALLOC: begin
                     addr_in       = CW'(1);
                     free_found_in = 1'b0;
                     max_in        = '0;
                     state_in      = BK_FIND;
                  end
                  OP_INSERT, OP_REMOVE, OP_MOVE_BEFORE, OP_MOVE_TAIL, OP_LOOKUP: begin
                     if (!q_item.a_ok) begin
                        res_in.status     = STS_INVALID;
                        res_in.handle_out = (q_item.op == OP_INSERT) ? '0 : q_item.handle_a;
                        res_in.rank_out   = '0;
                        state_in          = BK_RESP;
                     end else begin
                        state_in = BK_CHK_A;
                     end
                  end
                  default: begin
                     res_in.status     = STS_NO_CHANGE;
                     res_in.handle_out = q_item.handle_a;
                     res_in.rank_out   = '0;
                     state_in          = BK_RESP;
                  end
               endcase
            end
         end

         BK_CHK_A: begin
            rank_a_in         = ent.rank;
            res_in.status     = STS_DONE;
            res_in.handle_out = cmd_ff.handle_a;
            res_in.rank_out   = ent.rank;
            state_in          = BK_RESP;
            addr_in           = CW'(1);
            max_in            = '0;
            tail_found_in     = 1'b0;
            free_found_in     = 1'b0;
            rd_addr           = idx_b;
            if (!ent_match_a) begin
               res_in.status     = STS_INVALID;
               res_in.handle_out = (cmd_ff.op == OP_INSERT) ? '0 : cmd_ff.handle_a;
               res_in.rank_out   = '0;
            end else begin
               unique case (cmd_ff.op)
                  OP_INSERT:               state_in = BK_FIND;
                  OP_REMOVE, OP_MOVE_TAIL: state_in = BK_RENUM;
                  OP_MOVE_BEFORE: begin
                     if (!cmd_ff.b_ok) begin
                        res_in.status   = STS_INVALID;
                        res_in.rank_out = '0;
                     end else begin
                        state_in = BK_CHK_B;
                     end
                  end
                  default: state_in = BK_RESP;
               endcase
            end
         end

         BK_CHK_B: begin
            rank_b_in         = ent.rank;
            res_in.handle_out = cmd_ff.handle_a;
            if (!ent_match_b) begin
               res_in.status   = STS_INVALID;
               res_in.rank_out = '0;
               state_in        = BK_RESP;
            end else if (cmd_ff.same) begin
               res_in.status   = STS_NO_CHANGE;
               res_in.rank_out = rank_a_ff;
               state_in        = BK_RESP;
            end else begin
               state_in = BK_RENUM;
            end
         end

         BK_FIND: begin
            if (issue) begin
               rd_vld_in  = 1'b1;
               rd_addr_in = addr_ff[IW-1:0];
               addr_in    = addr_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if (!ent.used && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_addr_ff;
               end
               if (ent.used && (ent.rank > max_ff)) begin
                  max_in = ent.rank;
               end
            end
            if (scan_done) begin
               if (!free_found_ff) begin
                  res_in.status     = STS_FULL;
                  res_in.handle_out = '0;
                  res_in.rank_out   = '0;
                  state_in          = BK_RESP;
               end else if (cmd_ff.op == OP_ALLOC) begin
                  state_in = BK_COMMIT;
               end else begin
                  // the new slot is still free, so the pass leaves it alone
                  addr_in  = CW'(1);
                  state_in = BK_RENUM;
               end
            end
         end

         BK_RENUM: begin
            if (issue) begin
               rd_vld_in  = 1'b1;
               rd_addr_in = addr_ff[IW-1:0];
               addr_in    = addr_ff + CW'(1);
            end
            if (rd_vld_ff && ent.used && hit) begin
               wr_en   = 1'b1;
               wr_data = {ent.used, ent.serial, new_rank};
               if (cmd_ff.op == OP_MOVE_TAIL) begin
                  tail_found_in = 1'b1;
                  if (!tail_found_ff || (ent.rank > max_ff)) begin
                     max_in = ent.rank;
                  end
               end
            end
            if (scan_done) begin
               state_in = BK_COMMIT;
            end
         end

         BK_COMMIT: begin
            res_in.status     = STS_DONE;
            res_in.handle_out = cmd_ff.handle_a;
            res_in.rank_out   = rank_a_ff;
            state_in          = BK_RESP;
            wr_en             = 1'b1;
            wr_addr           = idx_a;
            wr_data           = {1'b1, ser_a, rank_a_ff};
            unique case (cmd_ff.op)
               OP_ALLOC, OP_INSERT: begin
                  serial_in         = new_ser;
                  wr_addr           = free_idx_ff;
                  res_in.handle_out = {new_ser, 16'(free_idx_ff)};
                  if (cmd_ff.op == OP_ALLOC) begin
                     res_in.rank_out = max_ff + 16'd1;
                  end
                  wr_data = {1'b1, new_ser, res_in.rank_out};
               end
               OP_REMOVE: begin
                  wr_data = {1'b0, ser_a, rank_a_ff};
               end
               OP_MOVE_BEFORE: begin
                  if (rank_a_ff < rank_b_ff) begin
                     res_in.rank_out = rank_lo_b;
                  end else begin
                     res_in.rank_out = rank_b_ff;
                     state_in        = BK_COMMIT_B;
                  end
                  wr_data = {1'b1, ser_a, res_in.rank_out};
               end
               OP_MOVE_TAIL: begin
                  if (tail_found_ff) begin
                     res_in.rank_out = max_ff;
                     wr_data         = {1'b1, ser_a, max_ff};
                  end else begin
                     res_in.status = STS_NO_CHANGE;
                     wr_en         = 1'b0;
                  end
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
         end

         BK_COMMIT_B: begin
            wr_en    = 1'b1;
            wr_addr  = idx_b;
            wr_data  = {1'b1, ser_b, rank_b_ff + 16'd1};
            state_in = BK_RESP;
         end

         BK_RESP: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in = 1'b1;
               rsp_in     = res_ff;
               state_in   = BK_IDLE;
            end
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_CLEAR;
         addr_ff    <= '0;
         rd_vld_ff  <= 1'b0;
         serial_ff  <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         rd_vld_ff  <= rd_vld_in;
         serial_ff  <= serial_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      cmd_ff        <= cmd_in;
      rank_a_ff     <= rank_a_in;
      rank_b_ff     <= rank_b_in;
      rd_addr_ff    <= rd_addr_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      max_ff        <= max_in;
      tail_found_ff <= tail_found_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end
endmodule
